### sv/deq_pkg.sv
// deq_pkg: shared types for the double-ended queue core
// operation codes, result status codes and the control state machine encoding
// no dependencies
`default_nettype none

package deq_pkg;

   localparam int unsigned OP_W     = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned FIELD_W  = 32;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

endpackage

`default_nettype wire

### sv/deq_ram.sv
// deq_ram: ring store of the queue, one write port and one read port
// read data is registered, so it shows in the cycle after the read is issued
// no package dependencies
`default_nettype none

module deq_ram #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned ADDR_W     = 4
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output logic      [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/deq_ctrl.sv
// deq_ctrl: front/back indices, entry count, request decode and result register
// drives the ring store ports and passes through a read state for read data on pop and peek
// depends on deq_pkg
`default_nettype none

module deq_ctrl #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned ADDR_W     = 4,
   parameter int unsigned CNT_W      = 5
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [deq_pkg::OP_W-1:0]           req_op,
   input  wire logic [deq_pkg::FIELD_W-1:0]        req_value_in,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [deq_pkg::FIELD_W-1:0]        rsp_value_out,
   output logic                                    rsp_now_empty,
   output logic      [deq_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                    wr_en,
   output logic      [ADDR_W-1:0]                  wr_addr,
   output logic      [DATA_WIDTH-1:0]              wr_data,
   output logic                                    rd_en,
   output logic      [ADDR_W-1:0]                  rd_addr,
   input  wire logic [DATA_WIDTH-1:0]              rd_data
);

   localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

   deq_pkg::state_type state_ff, state_in;

   logic [ADDR_W-1:0] front_ff, front_in;
   logic [ADDR_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pend_empty_ff, pend_empty_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::FIELD_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                            rsp_empty_ff, rsp_empty_in;
   logic [deq_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  is_empty, is_full;
   logic [ADDR_W-1:0]     front_next, front_prev, back_next, back_prev;
   logic                  do_write, do_read;
   logic [ADDR_W-1:0]     wr_addr_d, rd_addr_d;
   logic [ADDR_W-1:0]     front_d, back_d;
   logic [CNT_W-1:0]      count_d;
   deq_pkg::status_type   status_d;

   assign req_ready = (state_ff == deq_pkg::S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == FULL_CNT);
   assign front_next = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign front_prev = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign back_next  = (back_ff == LAST_IDX) ? '0 : back_ff + 1'b1;
   assign back_prev  = (back_ff == '0) ? LAST_IDX : back_ff - 1'b1;

   // request decode: one ring access and one index move at most
   always_comb begin
      do_write  = 1'b0;
      do_read   = 1'b0;
      wr_addr_d = back_ff;
      rd_addr_d = front_ff;
      front_d   = front_ff;
      back_d    = back_ff;
      count_d   = count_ff;
      status_d  = deq_pkg::STATUS_OK;
      unique case (deq_pkg::op_type'(req_op))
         deq_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
               status_d = deq_pkg::STATUS_FULL;
            end else begin
               do_write  = 1'b1;
               wr_addr_d = front_prev;
               front_d   = front_prev;
               count_d   = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
               status_d = deq_pkg::STATUS_FULL;
            end else begin
               do_write  = 1'b1;
               wr_addr_d = back_ff;
               back_d    = back_next;
               count_d   = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
               status_d = deq_pkg::STATUS_EMPTY;
            end else begin
               do_read   = 1'b1;
               rd_addr_d = front_ff;
               front_d   = front_next;
               count_d   = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (is_empty) begin
               status_d = deq_pkg::STATUS_EMPTY;
            end else begin
               do_read   = 1'b1;
               rd_addr_d = back_prev;
               back_d    = back_prev;
               count_d   = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_PEEK_FRONT: begin
            if (is_empty) begin
               status_d = deq_pkg::STATUS_EMPTY;
            end else begin
               do_read   = 1'b1;
               rd_addr_d = front_ff;
            end
         end
         deq_pkg::OP_PEEK_BACK: begin
            if (is_empty) begin
               status_d = deq_pkg::STATUS_EMPTY;
            end else begin
               do_read   = 1'b1;
               rd_addr_d = back_prev;
            end
         end
         default: begin
            // undefined codes leave everything as is
         end
      endcase
   end

   assign wr_en   = accept && do_write;
   assign wr_addr = wr_addr_d;
   assign wr_data = DATA_WIDTH'(req_value_in);
   assign rd_en   = accept && do_read;
   assign rd_addr = rd_addr_d;

   assign front_in      = accept ? front_d : front_ff;
   assign back_in       = accept ? back_d : back_ff;
   assign count_in      = accept ? count_d : count_ff;
   assign pend_empty_in = accept ? (count_d == '0) : pend_empty_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         deq_pkg::S_IDLE: begin
            if (accept && do_read) begin
               state_in = deq_pkg::S_READ;
            end
         end
         deq_pkg::S_READ: begin
            state_in = deq_pkg::S_IDLE;
         end
         default: begin
            state_in = deq_pkg::S_IDLE;
         end
      endcase
   end

   // result register: loaded at accept, or in the cycle after with read data
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         deq_pkg::S_IDLE: begin
            if (accept && !do_read) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_empty_in  = (count_d == '0);
               rsp_status_in = status_d;
            end
         end
         deq_pkg::S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = deq_pkg::FIELD_W'(rd_data);
            rsp_empty_in  = pend_empty_ff;
            rsp_status_in = deq_pkg::STATUS_OK;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::S_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_empty_ff <= pend_empty_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_now_empty = rsp_empty_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond depth");

   a_empty_ends_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_CNT) |-> (front_ff == back_ff))
      else $error("indices apart while queue empty or full");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == deq_pkg::S_READ) |-> !rsp_valid_ff)
      else $error("read data arriving while result register busy");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !accept |=> (count_ff == $past(count_ff)))
      else $error("entry count moved without a request");

   a_no_access_when_idle: assert property (@(posedge clock) disable iff (reset)
      (wr_en || rd_en) |-> accept && !(wr_en && rd_en))
      else $error("ring access without an accepted request");
`endif

endmodule

`default_nettype wire

### sv/double_ended_queue_core.sv
// Double-ended queue over a ring store of DEPTH words. Each request carries an operation
// (push front/back, pop front/back, peek front/back) and a data word; each one gives
// exactly one result with the word read, an empty flag after the step and a status
// (ok, empty error, full error). Errors and undefined codes leave the state untouched.
// Pushes, errors and undefined codes load the result at accept; pop and peek pass a read
// state first, because the ring store has a single registered read port and the word
// shows in the cycle after the read is issued. A result waits in an output register,
// and the next request is taken in the same cycle that the waiting result is taken.
// depends on deq_pkg, deq_ram, deq_ctrl
`default_nettype none

module double_ended_queue_core #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [deq_pkg::OP_W-1:0]        req_op,
   input  wire logic [deq_pkg::FIELD_W-1:0]     req_value_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [deq_pkg::FIELD_W-1:0]     rsp_value_out,
   output logic                                 rsp_now_empty,
   output logic      [deq_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   deq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (ADDR_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_now_empty (rsp_now_empty),
      .rsp_status    (rsp_status),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   deq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
